// ----- sv/tms_pkg.sv -----
// Package for the timed message scheduler: payload structs, slot record,
// request, mode, event and register codes, and shared constants.
// No dependencies.
package tms_pkg;

  localparam int DEF_MAX_ACTIVE  = 4;
  localparam int DEF_MAX_PENDING = 16;
  localparam int EV_DEPTH        = 15;
  localparam int EV_AW           = $clog2(EV_DEPTH);
  localparam int EV_CW           = $clog2(EV_DEPTH + 1);
  localparam logic [20:0] MIN_AUTO_MS = 21'd1000;

  localparam logic [1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [1:0] REQ_CANCEL  = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;
  localparam logic [1:0] REQ_TICK    = 2'd3;

  localparam logic [1:0] MODE_REPLACE  = 2'd0;
  localparam logic [1:0] MODE_FIFO     = 2'd1;
  localparam logic [1:0] MODE_PRIORITY = 2'd2;
  localparam logic [1:0] MODE_STACK    = 2'd3;

  localparam logic [1:0] EV_STARTED = 2'd0;
  localparam logic [1:0] EV_EXPIRED = 2'd1;
  localparam logic [1:0] EV_DONE    = 2'd2;

  localparam logic [1:0] CFG_QUEUE_MODE   = 2'd0;
  localparam logic [1:0] CFG_MAX_STACKED  = 2'd1;
  localparam logic [1:0] CFG_TIME_LETTER  = 2'd2;
  localparam logic [1:0] CFG_TIME_AFTER   = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] request_id;
    logic [7:0]  priority_req;
    logic        uninterruptible;
    logic [15:0] duration_ms;
    logic [15:0] delay_ms;
    logic [9:0]  text_length;
    logic [15:0] delta_ms;
  } tms_in_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] event_id;
    logic [15:0] top_active_id;
    logic        dropped;
    logic        last_of_run;
  } tms_out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic        unint;
    logic        started;
    logic [23:0] remaining;
    logic [15:0] delay;
  } slot_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
  } ev_t;

  typedef enum logic [2:0] {
    OP_HOLD, OP_INSERT, OP_REMOVE, OP_WRITE, OP_CLEAR
  } chain_op_t;

  typedef enum logic [1:0] {
    SEL_KEEP, SEL_LEFT, SEL_RIGHT, SEL_NEW
  } cell_sel_t;

  function automatic slot_t arm(slot_t s);
    slot_t r;
    r = s;
    r.started = (s.delay == 16'd0);
    return r;
  endfunction

endpackage

// ----- sv/tms_cell.sv -----
// One slot cell of a message chain: holds a slot record and loads it from
// a neighbour or from new data. Depends on tms_pkg.
module tms_cell import tms_pkg::*; (
  input  logic      clk,
  input  cell_sel_t sel,
  input  slot_t     left,
  input  slot_t     right,
  input  slot_t     din,
  output slot_t     q
);

  always_ff @(posedge clk) begin
    case (sel)
      SEL_LEFT:  q <= left;
      SEL_RIGHT: q <= right;
      SEL_NEW:   q <= din;
      default:   q <= q;
    endcase
  end

endmodule

// ----- sv/tms_chain.sv -----
// Row of slot cells with a fill count; insert and remove shift the cells from idx on,
// write loads the cell at idx, clear resets the count. Depends on tms_pkg and tms_cell.
module tms_chain import tms_pkg::*; #(
  parameter int N  = DEF_MAX_PENDING,
  parameter int CW = $clog2(N + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  chain_op_t     op,
  input  logic [CW-1:0] idx,
  input  slot_t         din,
  output slot_t         q [N],
  output logic [CW-1:0] count
);

  for (genvar j = 0; j < N; j++) begin : g_cell
    cell_sel_t sel;
    slot_t     left;
    slot_t     right;

    if (j == 0) begin : g_l0
      assign left = din;
    end else begin : g_ln
      assign left = q[j-1];
    end
    if (j == N - 1) begin : g_rl
      assign right = q[j];
    end else begin : g_rn
      assign right = q[j+1];
    end

    always_comb begin
      sel = SEL_KEEP;
      unique case (op)
        OP_INSERT: begin
          if (CW'(j) > idx) sel = SEL_LEFT;
          else if (CW'(j) == idx) sel = SEL_NEW;
        end
        OP_REMOVE: begin
          if (CW'(j) >= idx) sel = SEL_RIGHT;
        end
        OP_WRITE: begin
          if (CW'(j) == idx) sel = SEL_NEW;
        end
        default: sel = SEL_KEEP;
      endcase
    end

    tms_cell u_cell (
      .clk   (clk),
      .sel   (sel),
      .left  (left),
      .right (right),
      .din   (din),
      .q     (q[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (op)
        OP_INSERT: count <= count + CW'(1);
        OP_REMOVE: count <= count - CW'(1);
        OP_CLEAR:  count <= '0;
        default:   count <= count;
      endcase
    end
  end

endmodule

// ----- sv/tms_evq.sv -----
// Generic RAM: one write port and one registered read port, width and
// depth set by parameters. Depends on tms_pkg.
module tms_evq import tms_pkg::*; #(
  parameter int W     = $bits(ev_t),
  parameter int DEPTH = EV_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/timed_message_scheduler.sv -----
// Timed message scheduler top level: request, event and configuration
// channels, control sequencer. Depends on tms_pkg, tms_chain, tms_evq.
//
// Usage: a request transaction on req (valid/ready) carries enqueue, cancel,
// clear-all or tick. The block answers with one or more event transactions
// on evt: started and expired events, then a done item marked last_of_run
// that carries the assigned id (cancel: the cancelled id; clear, tick: 0) and
// the dropped flag; every item of a run carries the top active id as left after the request.
// The cfg channel writes queue_mode, max_stacked, time_per_letter_ms and
// time_after_ms by index; it is always ready and the user must use it only while idle (not enforced by the block).
// Timing: a request is taken only when the previous run is fully delivered.
// For clear and tick the sequencer walks the active cells one a cycle, a cell
// that expires on a tick adding a removal step; for a pending scan (priority
// insert, cancel) it scans the pending cells one a cycle. Results then stream
// at one per cycle while evt_ready is high; a stalled receiver holds the
// current item and the block waits. A new request is taken in the cycle after
// the last result.
// Reset (rst, synchronous) empties both chains, sets next id to 1 and loads
// the register defaults.
module timed_message_scheduler import tms_pkg::*; #(
  parameter int MAX_ACTIVE  = DEF_MAX_ACTIVE,
  parameter int MAX_PENDING = DEF_MAX_PENDING
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  tms_in_t     req,
  output logic        evt_valid,
  input  logic        evt_ready,
  output tms_out_t    evt,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int ACW = $clog2(MAX_ACTIVE + 1);
  localparam int PCW = $clog2(MAX_PENDING + 1);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_PREP    = 13'b0000000000010,
    S_DISP    = 13'b0000000000100,
    S_PUSH    = 13'b0000000001000,
    S_PSCAN   = 13'b0000000010000,
    S_CANCEL  = 13'b0000000100000,
    S_CLR     = 13'b0000001000000,
    S_TICK    = 13'b0000010000000,
    S_TICKEXP = 13'b0000100000000,
    S_ADV     = 13'b0001000000000,
    S_DONE    = 13'b0010000000000,
    S_DRAIN   = 13'b0100000000000,
    S_LOAD    = 13'b1000000000000
  } state_t;

  state_t           state, state_next;
  tms_in_t          req_r;
  slot_t            nslot, nslot_next;
  logic [ACW-1:0]   k, k_next;
  logic [PCW-1:0]   j, j_next;
  logic [MAX_PENDING-1:0] flags, flags_next;
  logic             found, found_next;
  logic [PCW-1:0]   found_idx, found_idx_next;
  logic             scan_first, scan_first_next;
  logic             dropped, dropped_next;
  logic [15:0]      done_id, done_id_next;
  logic [EV_CW-1:0] ev_cnt, ev_cnt_next;
  logic [EV_CW-1:0] rd, rd_next;
  logic [15:0]      next_id, next_id_next;

  logic [1:0]  queue_mode;
  logic [2:0]  max_stacked;
  logic [9:0]  time_per_letter;
  logic [15:0] time_after;

  chain_op_t      a_op, p_op;
  logic [ACW-1:0] a_idx;
  logic [PCW-1:0] p_idx;
  slot_t          a_din, p_din;
  slot_t          a_q [MAX_ACTIVE];
  slot_t          p_q [MAX_PENDING];
  logic [ACW-1:0] a_cnt;
  logic [PCW-1:0] p_cnt;

  logic  ev_we, ev_wr;
  ev_t   ev_w, ev_r;

  slot_t          a_km1, a_kc, a_top, old_slot, c_slot;
  logic [ACW-1:0] km1;
  logic           a_hit;
  logic [ACW-1:0] a_hit_idx;
  logic [MAX_PENDING-1:0] prio_flags, id_flags;
  logic [ACW-1:0] limit;
  logic [19:0]    prod;
  logic [20:0]    auto_sum;
  logic [23:0]    auto_rem;
  logic [15:0]    id_new, nid1, nid2;
  logic           tick_wait, adv_go, last_item;
  logic [15:0]    disp;
  logic [23:0]    rem_new;

  tms_chain #(.N(MAX_ACTIVE), .CW(ACW)) u_active (
    .clk(clk), .rst(rst), .op(a_op), .idx(a_idx), .din(a_din), .q(a_q), .count(a_cnt)
  );

  tms_chain #(.N(MAX_PENDING), .CW(PCW)) u_pending (
    .clk(clk), .rst(rst), .op(p_op), .idx(p_idx), .din(p_din), .q(p_q), .count(p_cnt)
  );

  assign ev_wr = ev_we && (ev_cnt < EV_CW'(EV_DEPTH));

  tms_evq #(.W($bits(ev_t)), .DEPTH(EV_DEPTH), .AW(EV_AW)) u_evq (
    .clk(clk), .we(ev_wr), .waddr(ev_cnt[EV_AW-1:0]), .wdata(ev_w),
    .raddr(rd_next[EV_AW-1:0]), .rdata(ev_r)
  );

  assign km1 = k - ACW'(1);

  always_comb begin
    a_km1     = a_q[0];
    a_kc      = a_q[0];
    a_top     = a_q[0];
    a_hit     = 1'b0;
    a_hit_idx = '0;
    for (int i = 0; i < MAX_ACTIVE; i++) begin
      if (ACW'(i) == km1) a_km1 = a_q[i];
      if (ACW'(i) == k) a_kc = a_q[i];
      if (ACW'(i) == a_cnt - ACW'(1)) a_top = a_q[i];
      if (ACW'(i) < a_cnt && a_q[i].id == req_r.request_id) begin
        a_hit     = 1'b1;
        a_hit_idx = ACW'(i);
      end
    end
    for (int i = 0; i < MAX_PENDING; i++) begin
      prio_flags[i] = (PCW'(i) < p_cnt) && (nslot.prio > p_q[i].prio);
      id_flags[i]   = (PCW'(i) < p_cnt) && (p_q[i].id == req_r.request_id);
    end
  end

  always_comb begin
    int m;
    m = int'(max_stacked);
    if (m < 1) m = 1;
    if (m > MAX_ACTIVE) m = MAX_ACTIVE;
    limit = ACW'(m);
  end

  assign prod     = req_r.text_length * time_per_letter;
  assign auto_sum = {1'b0, prod} + {5'd0, time_after};
  assign auto_rem = {3'd0, (auto_sum < MIN_AUTO_MS) ? MIN_AUTO_MS : auto_sum};

  assign id_new = (req_r.request_id != 16'd0) ? req_r.request_id : next_id;
  assign nid1   = (req_r.request_id != 16'd0) ? next_id :
                  ((next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1);
  assign nid2   = (id_new >= nid1) ? ((id_new == 16'hFFFF) ? 16'd1 : id_new + 16'd1) : nid1;

  always_comb begin
    old_slot         = a_q[0];
    old_slot.started = 1'b0;
    old_slot.delay   = 16'd0;
  end

  assign tick_wait = !a_km1.started && (a_km1.delay > req_r.delta_ms);
  assign disp      = a_km1.started ? req_r.delta_ms : req_r.delta_ms - a_km1.delay;
  assign rem_new   = (a_km1.remaining > {8'd0, disp}) ? a_km1.remaining - {8'd0, disp}
                                                      : 24'd0;

  always_comb begin
    c_slot = a_km1;
    if (tick_wait) begin
      c_slot.delay = a_km1.delay - req_r.delta_ms;
    end else begin
      c_slot.started   = 1'b1;
      c_slot.delay     = 16'd0;
      c_slot.remaining = rem_new;
    end
  end

  assign adv_go = (queue_mode == MODE_STACK) ? (a_cnt < limit && p_cnt != '0)
                                             : (a_cnt == '0 && p_cnt != '0);

  always_comb begin
    state_next      = state;
    nslot_next      = nslot;
    k_next          = k;
    j_next          = j;
    flags_next      = flags;
    found_next      = found;
    found_idx_next  = found_idx;
    scan_first_next = scan_first;
    dropped_next    = dropped;
    done_id_next    = done_id;
    next_id_next    = next_id;
    rd_next         = rd;
    a_op  = OP_HOLD;
    a_idx = '0;
    a_din = arm(nslot);
    p_op  = OP_HOLD;
    p_idx = '0;
    p_din = nslot;
    ev_we = 1'b0;
    ev_w  = '{kind: EV_STARTED, id: nslot.id};

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          dropped_next = 1'b0;
          state_next   = S_PREP;
        end
      end
      S_PREP: begin
        nslot_next.id        = id_new;
        nslot_next.prio      = req_r.priority_req;
        nslot_next.unint     = req_r.uninterruptible;
        nslot_next.started   = 1'b0;
        nslot_next.delay     = req_r.delay_ms;
        nslot_next.remaining = (req_r.duration_ms != 16'd0) ?
                               {8'd0, req_r.duration_ms} : auto_rem;
        unique case (req_r.req_type)
          REQ_ENQUEUE: begin
            done_id_next = id_new;
            next_id_next = nid2;
            state_next   = S_DISP;
          end
          REQ_CANCEL: begin
            done_id_next = req_r.request_id;
            state_next   = S_CANCEL;
          end
          REQ_CLEAR: begin
            done_id_next = 16'd0;
            k_next       = '0;
            state_next   = S_CLR;
          end
          default: begin
            done_id_next = 16'd0;
            k_next       = a_cnt;
            state_next   = S_TICK;
          end
        endcase
      end
      S_DISP: begin
        unique case (queue_mode)
          MODE_REPLACE: begin
            a_op       = OP_CLEAR;
            p_op       = OP_CLEAR;
            state_next = S_PUSH;
          end
          MODE_FIFO: begin
            if (a_cnt == '0) begin
              state_next = S_PUSH;
            end else begin
              if (p_cnt < PCW'(MAX_PENDING)) begin
                p_op  = OP_INSERT;
                p_idx = p_cnt;
              end else begin
                dropped_next = 1'b1;
              end
              state_next = S_DONE;
            end
          end
          MODE_PRIORITY: begin
            if (a_cnt == '0) begin
              state_next = S_PUSH;
            end else if (nslot.prio > a_q[0].prio && !a_q[0].unint) begin
              if (p_cnt < PCW'(MAX_PENDING)) begin
                p_op  = OP_INSERT;
                p_idx = '0;
                p_din = old_slot;
              end else begin
                dropped_next = 1'b1;
              end
              a_op  = OP_WRITE;
              a_idx = '0;
              ev_we = (nslot.delay == 16'd0);
              state_next = S_DONE;
            end else if (p_cnt >= PCW'(MAX_PENDING)) begin
              dropped_next = 1'b1;
              state_next   = S_DONE;
            end else begin
              flags_next      = prio_flags;
              j_next          = '0;
              found_next      = 1'b0;
              scan_first_next = 1'b1;
              state_next      = S_PSCAN;
            end
          end
          default: begin
            if (a_cnt >= limit) begin
              a_op  = OP_REMOVE;
              a_idx = '0;
              ev_we = 1'b1;
              ev_w  = '{kind: EV_EXPIRED, id: a_q[0].id};
            end
            state_next = S_PUSH;
          end
        endcase
      end
      S_PUSH: begin
        a_op  = OP_INSERT;
        a_idx = a_cnt;
        ev_we = (nslot.delay == 16'd0);
        state_next = S_DONE;
      end
      S_PSCAN: begin
        if (j == p_cnt || (scan_first && flags[0])) begin
          if (scan_first) begin
            p_op  = OP_INSERT;
            p_idx = j;
          end else if (found) begin
            p_op  = OP_REMOVE;
            p_idx = found_idx;
          end
          state_next = S_DONE;
        end else begin
          if (flags[0]) begin
            found_next     = 1'b1;
            found_idx_next = j;
          end
          flags_next = flags >> 1;
          j_next     = j + PCW'(1);
        end
      end
      S_CANCEL: begin
        if (a_hit) begin
          a_op  = OP_REMOVE;
          a_idx = a_hit_idx;
          ev_we = 1'b1;
          ev_w  = '{kind: EV_EXPIRED, id: req_r.request_id};
          state_next = S_ADV;
        end else begin
          flags_next      = id_flags;
          j_next          = '0;
          found_next      = 1'b0;
          scan_first_next = 1'b0;
          state_next      = S_PSCAN;
        end
      end
      S_CLR: begin
        if (k < a_cnt) begin
          ev_we  = 1'b1;
          ev_w   = '{kind: EV_EXPIRED, id: a_kc.id};
          k_next = k + ACW'(1);
        end else begin
          a_op       = OP_CLEAR;
          p_op       = OP_CLEAR;
          state_next = S_DONE;
        end
      end
      S_TICK: begin
        if (k == '0) begin
          state_next = S_ADV;
        end else begin
          a_op  = OP_WRITE;
          a_idx = km1;
          a_din = c_slot;
          ev_we = !tick_wait && !a_km1.started;
          ev_w  = '{kind: EV_STARTED, id: a_km1.id};
          if (!tick_wait && rem_new == 24'd0) state_next = S_TICKEXP;
          else k_next = km1;
        end
      end
      S_TICKEXP: begin
        a_op   = OP_REMOVE;
        a_idx  = km1;
        ev_we  = 1'b1;
        ev_w   = '{kind: EV_EXPIRED, id: a_km1.id};
        k_next = km1;
        state_next = S_TICK;
      end
      S_ADV: begin
        if (adv_go) begin
          p_op  = OP_REMOVE;
          p_idx = '0;
          a_op  = OP_INSERT;
          a_idx = a_cnt;
          a_din = arm(p_q[0]);
          ev_we = (p_q[0].delay == 16'd0);
          ev_w  = '{kind: EV_STARTED, id: p_q[0].id};
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        ev_we      = 1'b1;
        ev_w       = '{kind: EV_DONE, id: done_id};
        state_next = S_LOAD;
      end
      S_LOAD: begin
        rd_next    = '0;
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (evt_ready) begin
          if (last_item) state_next = S_IDLE;
          else rd_next = rd + EV_CW'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ev_cnt_next = ev_cnt;
    if (state == S_IDLE) ev_cnt_next = '0;
    else if (ev_wr) ev_cnt_next = ev_cnt + EV_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ev_cnt  <= '0;
      rd      <= '0;
      next_id <= 16'd1;
    end else begin
      state   <= state_next;
      ev_cnt  <= ev_cnt_next;
      rd      <= rd_next;
      next_id <= next_id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) req_r <= req;
    nslot      <= nslot_next;
    k          <= k_next;
    j          <= j_next;
    flags      <= flags_next;
    found      <= found_next;
    found_idx  <= found_idx_next;
    scan_first <= scan_first_next;
    dropped    <= dropped_next;
    done_id    <= done_id_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_mode      <= MODE_FIFO;
      max_stacked     <= 3'd1;
      time_per_letter <= 10'd50;
      time_after      <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_QUEUE_MODE:  queue_mode      <= cfg_data[1:0];
        CFG_MAX_STACKED: max_stacked     <= cfg_data[2:0];
        CFG_TIME_LETTER: time_per_letter <= cfg_data[9:0];
        default:         time_after      <= cfg_data;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign evt_valid = (state == S_DRAIN);
  assign last_item = (rd == ev_cnt - EV_CW'(1));

  assign evt.event_kind    = ev_r.kind;
  assign evt.event_id      = ev_r.id;
  assign evt.top_active_id = (a_cnt != '0) ? a_top.id : 16'd0;
  assign evt.dropped       = last_item && dropped;
  assign evt.last_of_run   = last_item;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> !req_ready)
    else $error("event output while accepting requests");

  a_ev_bound: assert property (@(posedge clk) disable iff (rst)
    ev_cnt <= EV_CW'(EV_DEPTH))
    else $error("event count overflow");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    a_cnt <= ACW'(MAX_ACTIVE) && p_cnt <= PCW'(MAX_PENDING))
    else $error("chain count beyond depth");

  a_return_idle: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && evt_ready && evt.last_of_run) |=> req_ready)
    else $error("no return to idle after last event");

endmodule

// ----- dv/timed_message_scheduler_checker.sv -----
// Checker for the timed message scheduler: watches the request, config and
// event channels, predicts each run of events and compares. Depends on tms_pkg.
module timed_message_scheduler_checker import tms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  tms_in_t     req,
  input  logic        evt_valid,
  input  logic        evt_ready,
  input  tms_out_t    evt,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          events_owed
);

  typedef struct {
    logic [15:0] id;
    logic [7:0]  prio;
    logic        unint;
    logic        started;
    logic [23:0] remaining;
    logic [15:0] delay;
  } msg_t;

  logic [1:0]  mode;
  logic [2:0]  stack_depth;
  logic [9:0]  per_letter;
  logic [15:0] after_ms;
  msg_t        shown[$];
  msg_t        waiting[$];
  logic [15:0] next_id;
  tms_out_t    owed_events[$];
  tms_out_t    run[$];

  assign events_owed = owed_events.size();

  function automatic void post(logic [1:0] kind, logic [15:0] id);
    tms_out_t e;
    if (run.size() >= EV_DEPTH) return;
    e = '0;
    e.event_kind = kind;
    e.event_id = id;
    run.push_back(e);
  endfunction

  function automatic int stack_cap();
    if (stack_depth < 1) return 1;
    if (stack_depth > DEF_MAX_ACTIVE) return DEF_MAX_ACTIVE;
    return stack_depth;
  endfunction

  function automatic void show(msg_t m);
    if (shown.size() >= DEF_MAX_ACTIVE) return;
    if (!m.started && m.delay == 0) begin
      m.started = 1;
      post(EV_STARTED, m.id);
    end
    shown.push_back(m);
  endfunction

  function automatic bit park(int pos, msg_t m);
    if (waiting.size() >= DEF_MAX_PENDING) return 0;
    if (pos > waiting.size()) pos = waiting.size();
    waiting.insert(pos, m);
    return 1;
  endfunction

  function automatic void promote();
    msg_t m;
    if (mode == MODE_STACK) begin
      while (shown.size() < stack_cap() && waiting.size() > 0) begin
        m = waiting.pop_front();
        show(m);
      end
    end else if (shown.size() == 0 && waiting.size() > 0) begin
      m = waiting.pop_front();
      show(m);
    end
  endfunction

  function automatic void schedule(tms_in_t r);
    msg_t        m, old;
    logic [15:0] done_id, top, id;
    logic        lost, found;
    logic [31:0] auto_ms;
    logic [31:0] disp;
    int          i;
    run.delete();
    done_id = 0;
    lost = 0;
    case (r.req_type)
      REQ_ENQUEUE: begin
        if (r.request_id != 0) id = r.request_id;
        else begin
          id = next_id;
          next_id = (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
        end
        if (id >= next_id) next_id = (id == 16'hFFFF) ? 16'd1 : id + 16'd1;
        m.id = id;
        m.prio = r.priority_req;
        m.unint = r.uninterruptible;
        m.started = 0;
        m.delay = r.delay_ms;
        if (r.duration_ms != 0) m.remaining = r.duration_ms;
        else begin
          auto_ms = r.text_length * per_letter + after_ms;
          m.remaining = (auto_ms < 1000) ? 24'd1000 : auto_ms[23:0];
        end
        done_id = id;
        case (mode)
          MODE_REPLACE: begin
            shown.delete();
            waiting.delete();
            show(m);
          end
          MODE_FIFO: begin
            if (shown.size() == 0) show(m);
            else if (!park(waiting.size(), m)) lost = 1;
          end
          MODE_PRIORITY: begin
            if (shown.size() == 0) show(m);
            else if (m.prio > shown[0].prio && !shown[0].unint) begin
              old = shown[0];
              old.started = 0;
              old.delay = 0;
              if (!park(0, old)) lost = 1;
              if (!m.started && m.delay == 0) begin
                m.started = 1;
                post(EV_STARTED, m.id);
              end
              shown[0] = m;
            end else begin
              for (i = 0; i < waiting.size(); i++)
                if (m.prio > waiting[i].prio) break;
              if (!park(i, m)) lost = 1;
            end
          end
          default: begin
            if (shown.size() >= stack_cap()) begin
              old = shown.pop_front();
              post(EV_EXPIRED, old.id);
            end
            show(m);
          end
        endcase
      end
      REQ_CANCEL: begin
        found = 0;
        done_id = r.request_id;
        for (i = shown.size() - 1; i >= 0; i--)
          if (shown[i].id == r.request_id) begin
            shown.delete(i);
            post(EV_EXPIRED, r.request_id);
            promote();
            found = 1;
            break;
          end
        if (!found)
          for (i = waiting.size() - 1; i >= 0; i--)
            if (waiting[i].id == r.request_id) begin
              waiting.delete(i);
              break;
            end
      end
      REQ_CLEAR: begin
        foreach (shown[j]) post(EV_EXPIRED, shown[j].id);
        shown.delete();
        waiting.delete();
      end
      default: begin
        for (i = shown.size() - 1; i >= 0; i--) begin
          disp = r.delta_ms;
          if (!shown[i].started) begin
            if (shown[i].delay > disp) begin
              shown[i].delay -= disp;
              continue;
            end
            disp -= shown[i].delay;
            shown[i].delay = 0;
            shown[i].started = 1;
            post(EV_STARTED, shown[i].id);
          end
          shown[i].remaining = (shown[i].remaining > disp) ?
                               shown[i].remaining - disp : 24'd0;
          if (shown[i].remaining == 0) begin
            id = shown[i].id;
            shown.delete(i);
            post(EV_EXPIRED, id);
          end
        end
        promote();
      end
    endcase
    post(EV_DONE, done_id);
    run[run.size() - 1].dropped = lost;
    run[run.size() - 1].last_of_run = 1;
    top = (shown.size() > 0) ? shown[shown.size() - 1].id : 16'd0;
    foreach (run[j]) begin
      run[j].top_active_id = top;
      owed_events.push_back(run[j]);
    end
  endfunction

  always @(posedge clk) begin
    tms_out_t x;
    if (rst) begin
      mode <= MODE_FIFO;
      stack_depth <= 3'd1;
      per_letter <= 10'd50;
      after_ms <= 16'd1000;
      shown.delete();
      waiting.delete();
      next_id = 16'd1;
      owed_events.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_QUEUE_MODE:  mode <= cfg_data[1:0];
          CFG_MAX_STACKED: stack_depth <= cfg_data[2:0];
          CFG_TIME_LETTER: per_letter <= cfg_data[9:0];
          default:         after_ms <= cfg_data;
        endcase
      end
      if (req_valid && req_ready) schedule(req);
      if (evt_valid && evt_ready) begin
        if (owed_events.size() == 0) begin
          $error("unexpected event transaction %p", evt);
          fail_count <= fail_count + 1;
        end else begin
          x = owed_events.pop_front();
          if (x != evt) begin
            if (x.event_kind != evt.event_kind)
              $error("event_kind exp %0d got %0d", x.event_kind, evt.event_kind);
            if (x.event_id != evt.event_id)
              $error("event_id exp %0d got %0d", x.event_id, evt.event_id);
            if (x.top_active_id != evt.top_active_id)
              $error("top_active_id exp %0d got %0d", x.top_active_id,
                     evt.top_active_id);
            if (x.dropped != evt.dropped)
              $error("dropped exp %0d got %0d", x.dropped, evt.dropped);
            if (x.last_of_run != evt.last_of_run)
              $error("last_of_run exp %0d got %0d", x.last_of_run, evt.last_of_run);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- dv/timed_message_scheduler_tb.sv -----
// Testbench top for the timed message scheduler: clock, reset, request and
// config stimulus, verdict. Depends on tms_pkg, the block and its checker.
module timed_message_scheduler_tb import tms_pkg::*;;

  logic     clk = 0;
  logic     rst = 1;
  logic     req_valid = 0;
  logic     req_ready;
  tms_in_t  req = '0;
  logic     evt_valid;
  logic     evt_ready = 0;
  tms_out_t evt;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int       fail_count, events_owed;
  int       cycles = 0;
  bit       calm = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  timed_message_scheduler uut (.*);
  timed_message_scheduler_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk)
    evt_ready <= calm || ($urandom_range(99) >= 26);

  task automatic send(tms_in_t r);
    while (!calm && $urandom_range(99) < 26) @(posedge clk);
    req_valid <= 1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    req_valid <= 0;
    @(posedge clk);
  endtask

  task automatic settle();
    @(posedge clk);
    while (events_owed != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic tms_in_t make_req(logic [1:0] kind);
    tms_in_t r;
    r = '0;
    r.req_type = kind;
    r.request_id = ($urandom_range(3) == 0) ? 16'd0 :
                   ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 24));
    r.priority_req = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
    r.uninterruptible = 1'($urandom_range(1));
    r.duration_ms = ($urandom_range(3) == 0) ? 16'd0 :
                    ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3000));
    r.delay_ms = ($urandom_range(1) == 0) ? 16'd0 :
                 ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1500));
    r.text_length = 10'($urandom);
    r.delta_ms = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2500));
    return r;
  endfunction

  function automatic tms_in_t pick_req();
    int w;
    w = $urandom_range(99);
    if (w < 45) return make_req(REQ_ENQUEUE);
    if (w < 57) return make_req(REQ_CANCEL);
    if (w < 61) return make_req(REQ_CLEAR);
    return make_req(REQ_TICK);
  endfunction

  initial begin
    tms_in_t r;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    r = '0;
    r.request_id = 16'hFFFF;
    r.priority_req = 8'hFF;
    r.uninterruptible = 1;
    r.duration_ms = 16'hFFFF;
    r.delay_ms = 16'hFFFF;
    r.text_length = 10'h3FF;
    r.delta_ms = 16'hFFFF;
    send(r);
    r.request_id = 0;
    r.duration_ms = 0;
    r.delay_ms = 0;
    send(r);
    r.req_type = REQ_TICK;
    send(r);
    send(r);
    r.req_type = REQ_CANCEL;
    r.request_id = 16'd777;
    send(r);
    r = '0;
    for (int i = 0; i < 18; i++) begin
      r.request_id = 16'(i + 1);
      r.duration_ms = 16'd5;
      send(r);
    end
    r.req_type = REQ_CLEAR;
    send(r);
    settle();

    write_reg(CFG_TIME_LETTER, 16'd1000);
    write_reg(CFG_TIME_AFTER, 16'hFFFF);
    write_reg(CFG_MAX_STACKED, 16'd0);
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_QUEUE_MODE, 16'(phase % 4));
      write_reg(CFG_MAX_STACKED, 16'($urandom_range(0, 7)));
      if (phase == 4) begin
        write_reg(CFG_TIME_LETTER, 16'd0);
        write_reg(CFG_TIME_AFTER, 16'd0);
      end else if (phase > 4) begin
        write_reg(CFG_TIME_LETTER, 16'($urandom_range(0, 1000)));
        write_reg(CFG_TIME_AFTER, 16'($urandom));
      end
      calm = (phase == 2);
      for (int n = 0; n < 26; n++) send(pick_req());
      settle();
    end
    calm = 0;

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
